// ----- rtl/core/jssc_pkg.sv -----
// Package: types, character codes and parser phases for the JSON subset syntax checker.
`default_nettype none
package jssc_pkg;

	localparam int MAX_DEPTH = 16;
	localparam int DEPTH_W   = 5;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LF     = 8'h0A;

	typedef enum logic [10:0] {
		PH_TOP      = 11'b000_0000_0001,
		PH_KEY      = 11'b000_0000_0010,
		PH_IN_KEY   = 11'b000_0000_0100,
		PH_COLON    = 11'b000_0000_1000,
		PH_VALUE    = 11'b000_0001_0000,
		PH_IN_VAL   = 11'b000_0010_0000,
		PH_LIST     = 11'b000_0100_0000,
		PH_IN_LIST  = 11'b000_1000_0000,
		PH_AFT_LIST = 11'b001_0000_0000,
		PH_AFT_MEM  = 11'b010_0000_0000,
		PH_DONE     = 11'b100_0000_0000
	} phase_t;

	typedef enum logic [2:0] {
		EK_NONE   = 3'd0,
		EK_STRING = 3'd1,
		EK_COLON  = 3'd2,
		EK_LIST   = 3'd3,
		EK_OBJECT = 3'd4,
		EK_END    = 3'd5
	} ek_t;

	typedef struct packed {
		phase_t               phase;
		logic [DEPTH_W-1:0]   depth;
		ek_t                  err;
	} pstate_t;

	localparam pstate_t PSTATE_RESET = '{phase: PH_TOP, depth: '0, err: EK_NONE};

endpackage
`default_nettype wire

// ----- rtl/core/jssc_step.sv -----
// Parser step: next phase, depth and latched error for one document byte.
`default_nettype none
module jssc_step
	import jssc_pkg::*;
(
	input  wire  [7:0] c,
	input  pstate_t    cur,
	output pstate_t    nxt
);

	logic               forbidden;
	logic [DEPTH_W-1:0] depth_dec;

	assign forbidden = c inside {CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COLON, CH_COMMA};
	assign depth_dec = (cur.depth != '0) ? cur.depth - 1'b1 : cur.depth;

	always_comb begin
		nxt = cur;
		if (cur.err == EK_NONE && c != CH_SPACE && c != CH_LF) begin
			case (cur.phase)
				PH_TOP: begin
					if (c == CH_LBRACE) begin
						nxt.depth = DEPTH_W'(1);
						nxt.phase = PH_KEY;
					end else begin
						nxt.err = EK_OBJECT;
					end
				end
				PH_KEY: begin
					if (c == CH_QUOTE) nxt.phase = PH_IN_KEY;
					else if (c == CH_RBRACE) nxt.err = EK_OBJECT;
					else nxt.err = EK_STRING;
				end
				PH_IN_KEY: begin
					if (c == CH_QUOTE) nxt.phase = PH_COLON;
					else if (forbidden) nxt.err = EK_STRING;
				end
				PH_COLON: begin
					if (c == CH_COLON) nxt.phase = PH_VALUE;
					else nxt.err = EK_COLON;
				end
				PH_VALUE: begin
					if (c == CH_QUOTE) nxt.phase = PH_IN_VAL;
					else if (c == CH_LBRACK) nxt.phase = PH_LIST;
					else if (c == CH_LBRACE) begin
						if (cur.depth >= DEPTH_W'(MAX_DEPTH)) begin
							nxt.err = EK_OBJECT;
						end else begin
							nxt.depth = cur.depth + 1'b1;
							nxt.phase = PH_KEY;
						end
					end else begin
						nxt.err = EK_OBJECT;
					end
				end
				PH_IN_VAL: begin
					if (c == CH_QUOTE) nxt.phase = PH_AFT_MEM;
					else if (forbidden) nxt.err = EK_STRING;
				end
				PH_LIST: begin
					if (c == CH_QUOTE) nxt.phase = PH_IN_LIST;
					else nxt.err = EK_LIST;
				end
				PH_IN_LIST: begin
					if (c == CH_QUOTE) nxt.phase = PH_AFT_LIST;
					else if (forbidden) nxt.err = EK_STRING;
				end
				PH_AFT_LIST: begin
					if (c == CH_COMMA) nxt.phase = PH_LIST;
					else if (c == CH_RBRACK) nxt.phase = PH_AFT_MEM;
					else nxt.err = EK_LIST;
				end
				PH_AFT_MEM: begin
					if (c == CH_COMMA) begin
						nxt.phase = PH_KEY;
					end else if (c == CH_RBRACE) begin
						nxt.depth = depth_dec;
						nxt.phase = (depth_dec == '0) ? PH_DONE : PH_AFT_MEM;
					end else begin
						nxt.err = EK_OBJECT;
					end
				end
				PH_DONE: nxt.err = EK_END;
				default: nxt.err = EK_OBJECT;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/json_subset_syntax_checker_top.sv -----
// Top level: input register, parser state, verdict register and handshakes.
// Verdict path: the last byte's word passes the input register, then the verdict register;
// it waits in the input register while an earlier verdict is still held.
// One byte per cycle unless stalled; the parser state update is a combinational step.
// The input stalls only while a verdict is held and the next last byte is waiting.
// Reset: asynchronous, active low; parser returns to expecting the top brace, no word held.
`default_nettype none
module json_subset_syntax_checker_top
	import jssc_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [7:0] char_in,
	input  wire        last_byte,
	output logic       out_valid,
	input  wire        out_ready,
	output logic       doc_valid,
	output logic [2:0] error_kind
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	pstate_t    state_q;
	pstate_t    state_nxt;
	logic       out_free;
	logic       advance;
	ek_t        kind;
	logic       doc_q;
	ek_t        kind_q;

	jssc_step u_step (
		.c   (char_s1),
		.cur (state_q),
		.nxt (state_nxt)
	);

	assign out_free = !out_valid || out_ready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || advance;

	assign kind = (state_nxt.err == EK_NONE && state_nxt.phase != PH_DONE) ? EK_END
		: state_nxt.err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			state_q   <= PSTATE_RESET;
			out_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;

			if (advance) state_q <= last_s1 ? PSTATE_RESET : state_nxt;

			if (advance && last_s1) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
			last_s1 <= last_byte;
		end
		if (advance && last_s1) begin
			kind_q <= kind;
			doc_q  <= (kind == EK_NONE);
		end
	end

	assign doc_valid  = doc_q;
	assign error_kind = kind_q;

endmodule
`default_nettype wire
